// ----- hdl/bcpg_pkg.sv -----
// shared types and constants of the bezier curve point generator
package bcpg_pkg;

    // coordinate and index widths
    localparam int CoordW   = 16;
    localparam int IdxW     = 6;
    localparam int MaxSteps = 63;

    // curve order codes
    localparam logic [1:0] OP_LINEAR = 2'd0;
    localparam logic [1:0] OP_QUAD   = 2'd1;
    localparam logic [1:0] OP_CUBIC  = 2'd2;

    // datapath widths
    localparam int SqW  = 2 * IdxW;          // u*u, u*i, i*i, n*n
    localparam int WW   = 20;                // bernstein weight, up to 3*63^3
    localparam int DW   = 3 * IdxW;          // n^3
    localparam int PW   = WW + 1 + CoordW;   // weight times coordinate
    localparam int SumW = PW + 2;            // sum of four products
    localparam int NW   = SumW + 1;          // 2*|s| + d
    localparam int QW   = CoordW + 1;        // rounded quotient magnitude

    typedef struct packed {
        logic [1:0]               opcode;
        logic signed [CoordW-1:0] start_x;
        logic signed [CoordW-1:0] start_y;
        logic signed [CoordW-1:0] ctrl1_x;
        logic signed [CoordW-1:0] ctrl1_y;
        logic signed [CoordW-1:0] ctrl2_x;
        logic signed [CoordW-1:0] ctrl2_y;
        logic signed [CoordW-1:0] end_x;
        logic signed [CoordW-1:0] end_y;
        logic [IdxW-1:0]          step_count;
    } t_in_item;

    typedef struct packed {
        logic signed [CoordW-1:0] point_x;
        logic signed [CoordW-1:0] point_y;
        logic [IdxW-1:0]          point_index;
        logic                     last;
    } t_out_item;

    // control points: [point][lane], lane 0 is x
    typedef logic [3:0][1:0][CoordW-1:0] t_pts;

    // weighted sum handed to the divider
    typedef struct packed {
        logic [1:0][SumW-1:0] mag;
        logic [1:0]           neg;
        logic [DW-1:0]        den;
        logic [IdxW-1:0]      idx;
        logic                 last;
    } t_sum_item;

endpackage

// ----- hdl/bezier_curve_point_generator_core.sv -----
// top level of the bezier curve point generator
// Takes one curve item (linear, quadratic or cubic, step count N, zero read as
// one) and emits N+1 points for t = i/N, one point per cycle while the output
// is not stalled, each coordinate the exact bernstein sum divided by N^degree,
// rounded half away from zero. An item occupies the index sequencer from its
// load until its last index has been issued; the next item is taken once the
// last index of the current one has been issued. Points pass a 4-stage sum
// pipeline, an 18-stage divider and the output register. An output stall
// freezes the whole pipeline.
module bezier_curve_point_generator_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  bcpg_pkg::t_in_item    i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output bcpg_pkg::t_out_item   o_out_item
);

    localparam int IdxW   = bcpg_pkg::IdxW;
    localparam int CoordW = bcpg_pkg::CoordW;
    localparam int QW     = bcpg_pkg::QW;

    logic                 r_busy;
    logic [IdxW-1:0]      r_idx;
    logic [IdxW-1:0]      r_n;
    logic [1:0]           r_op;
    bcpg_pkg::t_pts       r_pts;
    logic                 r_out_valid;
    bcpg_pkg::t_out_item  r_out_item;

    logic                 w_en;
    logic [IdxW-1:0]      n_n;
    logic                 w_sum_valid;
    bcpg_pkg::t_sum_item  w_sum_item;
    logic                 w_div_valid;
    logic [1:0][QW-1:0]   w_q;
    logic [1:0]           w_neg;
    logic [IdxW-1:0]      w_idx;
    logic                 w_last;
    logic [1:0][CoordW-1:0] n_coord;

    // pipeline moves unless a held point is stalled
    assign w_en       = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_busy;

    // step count: zero means one, clamp to the supported maximum
    always_comb begin
        n_n = (i_in_item.step_count == '0) ? IdxW'(1) : i_in_item.step_count;
        if (n_n > IdxW'(bcpg_pkg::MaxSteps)) begin
            n_n = IdxW'(bcpg_pkg::MaxSteps);
        end
    end

    // index sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (!r_busy) begin
            r_busy <= i_in_valid;
        end else if (w_en && r_idx == r_n) begin
            r_busy <= 1'b0;
        end
    end

    // index sequencer payload
    always_ff @(posedge i_clk) begin
        if (!r_busy) begin
            r_idx <= '0;
            if (i_in_valid) begin
                r_n   <= n_n;
                r_op  <= i_in_item.opcode;
                r_pts <= {i_in_item.end_y,   i_in_item.end_x,
                          i_in_item.ctrl2_y, i_in_item.ctrl2_x,
                          i_in_item.ctrl1_y, i_in_item.ctrl1_x,
                          i_in_item.start_y, i_in_item.start_x};
            end
        end else if (w_en) begin
            r_idx <= r_idx + IdxW'(1);
        end
    end

    bcpg_sum u_sum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_valid  (r_busy),
        .i_opcode (r_op),
        .i_n      (r_n),
        .i_idx    (r_idx),
        .i_pts    (r_pts),
        .o_valid  (w_sum_valid),
        .o_item   (w_sum_item)
    );

    bcpg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_sum_valid),
        .i_item  (w_sum_item),
        .o_valid (w_div_valid),
        .o_q     (w_q),
        .o_neg   (w_neg),
        .o_idx   (w_idx),
        .o_last  (w_last)
    );

    // sign and clamp of the rounded quotient
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (w_neg[l]) begin
                if (w_q[l] > (QW'(1) << (CoordW - 1))) begin
                    n_coord[l] = {1'b1, {(CoordW-1){1'b0}}};
                end else begin
                    n_coord[l] = CoordW'(-w_q[l]);
                end
            end else if (|w_q[l][QW-1:CoordW-1]) begin
                n_coord[l] = {1'b0, {(CoordW-1){1'b1}}};
            end else begin
                n_coord[l] = CoordW'(w_q[l]);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_div_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_item.point_x     <= n_coord[0];
            r_out_item.point_y     <= n_coord[1];
            r_out_item.point_index <= w_idx;
            r_out_item.last        <= w_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ----- hdl/bcpg_sum.sv -----
// bernstein weights and weighted sums of the control points, four stages
module bcpg_sum (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic [1:0]                    i_opcode,
    input  logic [bcpg_pkg::IdxW-1:0]     i_n,
    input  logic [bcpg_pkg::IdxW-1:0]     i_idx,
    input  bcpg_pkg::t_pts                i_pts,
    output logic                          o_valid,
    output bcpg_pkg::t_sum_item           o_item
);

    localparam int IdxW   = bcpg_pkg::IdxW;
    localparam int SqW    = bcpg_pkg::SqW;
    localparam int WW     = bcpg_pkg::WW;
    localparam int DW     = bcpg_pkg::DW;
    localparam int PW     = bcpg_pkg::PW;
    localparam int SumW   = bcpg_pkg::SumW;

    logic [3:0] r_v;

    // stage 1 registers
    logic [SqW-1:0]  r1_u2, r1_ui, r1_i2, r1_n2;
    logic [IdxW-1:0] r1_u, r1_i, r1_n;
    logic [1:0]      r1_op;
    logic            r1_last;
    bcpg_pkg::t_pts  r1_pts;

    // stage 2 registers
    logic [3:0][WW-1:0] r2_w;
    logic [DW-1:0]      r2_d;
    logic [IdxW-1:0]    r2_i;
    logic               r2_last;
    bcpg_pkg::t_pts     r2_pts;

    // stage 3 registers
    logic signed [PW-1:0] r3_p [2][4];
    logic [DW-1:0]        r3_d;
    logic [IdxW-1:0]      r3_i;
    logic                 r3_last;

    // stage 4 register
    bcpg_pkg::t_sum_item r4_item;

    logic [IdxW-1:0]    n_u;
    logic [3:0][WW-1:0] n_w;
    logic [DW-1:0]      n_d;
    logic signed [SumW-1:0] n_s [2];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    assign n_u = i_n - i_idx;

    // weight selection by curve order
    always_comb begin
        case (r1_op)
            bcpg_pkg::OP_LINEAR: begin
                n_w[0] = WW'(r1_u);
                n_w[1] = '0;
                n_w[2] = '0;
                n_w[3] = WW'(r1_i);
                n_d    = DW'(r1_n);
            end
            bcpg_pkg::OP_QUAD: begin
                n_w[0] = WW'(r1_u2);
                n_w[1] = WW'(r1_ui) << 1;
                n_w[2] = '0;
                n_w[3] = WW'(r1_i2);
                n_d    = DW'(r1_n2);
            end
            default: begin
                n_w[0] = WW'(r1_u2) * WW'(r1_u);
                n_w[1] = WW'(r1_u2) * WW'(r1_i) * WW'(3);
                n_w[2] = WW'(r1_ui) * WW'(r1_i) * WW'(3);
                n_w[3] = WW'(r1_i2) * WW'(r1_i);
                n_d    = DW'(r1_n2) * DW'(r1_n);
            end
        endcase
    end

    // four products per lane added up
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            n_s[l] = SumW'(r3_p[l][0]) + SumW'(r3_p[l][1])
                   + SumW'(r3_p[l][2]) + SumW'(r3_p[l][3]);
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_u    <= n_u;
            r1_i    <= i_idx;
            r1_n    <= i_n;
            r1_u2   <= SqW'(n_u) * SqW'(n_u);
            r1_ui   <= SqW'(n_u) * SqW'(i_idx);
            r1_i2   <= SqW'(i_idx) * SqW'(i_idx);
            r1_n2   <= SqW'(i_n) * SqW'(i_n);
            r1_op   <= i_opcode;
            r1_last <= (i_idx == i_n);
            r1_pts  <= i_pts;

            r2_w    <= n_w;
            r2_d    <= n_d;
            r2_i    <= r1_i;
            r2_last <= r1_last;
            r2_pts  <= r1_pts;

            for (int l = 0; l < 2; l++) begin
                for (int k = 0; k < 4; k++) begin
                    r3_p[l][k] <= PW'($signed({1'b0, r2_w[k]})
                                * $signed(r2_pts[k][l]));
                end
            end
            r3_d    <= r2_d;
            r3_i    <= r2_i;
            r3_last <= r2_last;

            for (int l = 0; l < 2; l++) begin
                r4_item.neg[l] <= n_s[l][SumW-1];
                r4_item.mag[l] <= n_s[l][SumW-1] ? SumW'(-n_s[l]) : SumW'(n_s[l]);
            end
            r4_item.den  <= r3_d;
            r4_item.idx  <= r3_i;
            r4_item.last <= r3_last;
        end
    end

    assign o_valid = r_v[3];
    assign o_item  = r4_item;

endmodule

// ----- hdl/bcpg_div.sv -----
// pipelined restoring divider, one quotient bit per stage, two lanes
module bcpg_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  bcpg_pkg::t_sum_item               i_item,
    output logic                              o_valid,
    output logic [1:0][bcpg_pkg::QW-1:0]      o_q,
    output logic [1:0]                        o_neg,
    output logic [bcpg_pkg::IdxW-1:0]         o_idx,
    output logic                              o_last
);

    localparam int QW   = bcpg_pkg::QW;
    localparam int NW   = bcpg_pkg::NW;
    localparam int DW   = bcpg_pkg::DW;
    localparam int IdxW = bcpg_pkg::IdxW;

    logic                   r_v    [QW+1];
    logic [1:0][NW-1:0]     r_rem  [QW+1];
    logic [1:0][QW-1:0]     r_q    [QW+1];
    logic [DW:0]            r_den  [QW+1];
    logic [1:0]             r_neg  [QW+1];
    logic [IdxW-1:0]        r_idx  [QW+1];
    logic                   r_last [QW+1];

    logic [1:0][NW-1:0] n_rem [QW];
    logic [1:0][QW-1:0] n_q   [QW];

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '{default: 1'b0};
        end else if (i_en) begin
            r_v[0] <= i_valid;
            for (int k = 0; k < QW; k++) begin
                r_v[k+1] <= r_v[k];
            end
        end
    end

    // trial subtract of the shifted divisor in each stage
    always_comb begin
        logic [NW-1:0] v_trial;
        for (int k = 0; k < QW; k++) begin
            v_trial = NW'(r_den[k]) << (QW - 1 - k);
            for (int l = 0; l < 2; l++) begin
                if (r_rem[k][l] >= v_trial) begin
                    n_rem[k][l] = r_rem[k][l] - v_trial;
                    n_q[k][l]   = r_q[k][l] | (QW'(1) << (QW - 1 - k));
                end else begin
                    n_rem[k][l] = r_rem[k][l];
                    n_q[k][l]   = r_q[k][l];
                end
            end
        end
    end

    // numerator 2|s|+d over divisor 2d rounds half away from zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int l = 0; l < 2; l++) begin
                r_rem[0][l] <= (NW'(i_item.mag[l]) << 1) + NW'(i_item.den);
            end
            r_q[0]    <= '0;
            r_den[0]  <= {i_item.den, 1'b0};
            r_neg[0]  <= i_item.neg;
            r_idx[0]  <= i_item.idx;
            r_last[0] <= i_item.last;
            for (int k = 0; k < QW; k++) begin
                r_rem[k+1]  <= n_rem[k];
                r_q[k+1]    <= n_q[k];
                r_den[k+1]  <= r_den[k];
                r_neg[k+1]  <= r_neg[k];
                r_idx[k+1]  <= r_idx[k];
                r_last[k+1] <= r_last[k];
            end
        end
    end

    assign o_valid = r_v[QW];
    assign o_q     = r_q[QW];
    assign o_neg   = r_neg[QW];
    assign o_idx   = r_idx[QW];
    assign o_last  = r_last[QW];

endmodule
